FILE: design/kvlp_pkg.sv
// ----------------------------------------------------------------------------
// Key/value line parser package
// Shared constants, types and character classes of the line parser.
// ----------------------------------------------------------------------------
package kvlp_pkg;

   localparam int MAX_LINE_DEFAULT = 256;
   localparam int SPAN_W = 9;

   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_EQ    = 8'h3d;
   localparam logic [7:0] CH_UNDER = 8'h5f;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;

   typedef enum logic [2:0] {
      PH_LEAD    = 3'd0,
      PH_NAME    = 3'd1,
      PH_PRE_EQ  = 3'd2,
      PH_POST_EQ = 3'd3,
      PH_VALUE   = 3'd4,
      PH_QVALUE  = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      ST_BLANK  = 2'd0,
      ST_PARSED = 2'd1,
      ST_ERROR  = 2'd2
   } status_type;

   typedef struct packed {
      status_type          status;
      logic [SPAN_W-1:0]   option_pos;
      logic [SPAN_W-1:0]   option_length;
      logic [SPAN_W-1:0]   value_pos;
      logic [SPAN_W-1:0]   value_length;
   } result_type;

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB);
   endfunction

   function automatic logic is_name_char(input logic [7:0] c);
      return (c inside {[8'h61:8'h7a], [8'h41:8'h5a], [8'h30:8'h39], CH_UNDER});
   endfunction

endpackage

FILE: design/kvlp_in_stage.sv
// ----------------------------------------------------------------------------
// Key/value line parser input stage
// Registers one character transaction and holds it until the parser takes it.
// ----------------------------------------------------------------------------
module kvlp_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_ch,
   input  logic       req_last_char,
   input  logic       go,
   output logic       in_valid,
   output logic [7:0] in_ch,
   output logic       in_last
);

   logic       valid_ff;
   logic [7:0] ch_ff;
   logic       last_ff;

   assign req_stall = valid_ff && !go;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!req_stall) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         ch_ff   <= req_ch;
         last_ff <= req_last_char;
      end
   end

   assign in_valid = valid_ff;
   assign in_ch    = ch_ff;
   assign in_last  = last_ff;

endmodule

FILE: design/kvlp_parse.sv
// ----------------------------------------------------------------------------
// Key/value line parser step
// Phase machine and span registers; updated once per character and
// producing the result on the last character of a line.
// ----------------------------------------------------------------------------
module kvlp_parse #(
   parameter int MAX_LINE = kvlp_pkg::MAX_LINE_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                go,
   input  logic [7:0]          ch,
   input  logic                last,
   output logic                res_valid,
   output kvlp_pkg::result_type res
);

   localparam int PW   = $clog2(MAX_LINE + 1);
   localparam int WIDE = (PW > kvlp_pkg::SPAN_W) ? PW : kvlp_pkg::SPAN_W;

   kvlp_pkg::phase_type phase_ff, phase_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic          inq_ff, inq_in;
   logic          cut_ff, cut_in;
   logic [PW-1:0] name_start_ff, name_start_in;
   logic [PW-1:0] name_count_ff, name_count_in;
   logic [PW-1:0] val_start_ff, val_start_in;
   logic          quoted_ff, quoted_in;
   logic [PW-1:0] lnb_ff, lnb_in;
   logic [PW-1:0] lq_ff, lq_in;
   logic          lq_seen_ff, lq_seen_in;
   logic          err_ff, err_in;

   always_comb begin
      logic          live;
      logic [PW-1:0] pos1;
      logic [PW-1:0] vlen;
      logic [WIDE-1:0] wide;
      phase_in      = phase_ff;
      pos_in        = pos_ff;
      inq_in        = inq_ff;
      cut_in        = cut_ff;
      name_start_in = name_start_ff;
      name_count_in = name_count_ff;
      val_start_in  = val_start_ff;
      quoted_in     = quoted_ff;
      lnb_in        = lnb_ff;
      lq_in         = lq_ff;
      lq_seen_in    = lq_seen_ff;
      err_in        = err_ff;
      live          = 1'b0;
      pos1          = pos_ff + PW'(1);
      vlen          = '0;
      wide          = '0;
      res           = '0;
      res.status    = kvlp_pkg::ST_BLANK;

      if (pos_ff >= PW'(MAX_LINE)) begin
         err_in = 1'b1;
      end else begin
         pos_in = pos1;
         live   = !cut_ff;
         if (live) begin
            if (ch == kvlp_pkg::CH_QUOTE) begin
               inq_in = !inq_ff;
            end else if (ch == kvlp_pkg::CH_HASH && !inq_ff) begin
               cut_in = 1'b1;
               live   = 1'b0;
            end
         end
         if (live) begin
            if (!kvlp_pkg::is_blank(ch)) begin
               lnb_in = pos1;
            end
            if (!err_ff) begin
               case (phase_ff)
                  kvlp_pkg::PH_LEAD: begin
                     if (kvlp_pkg::is_name_char(ch)) begin
                        phase_in      = kvlp_pkg::PH_NAME;
                        name_start_in = pos_ff;
                        name_count_in = PW'(1);
                     end else if (!kvlp_pkg::is_blank(ch)) begin
                        err_in = 1'b1;
                     end
                  end
                  kvlp_pkg::PH_NAME: begin
                     if (kvlp_pkg::is_name_char(ch)) begin
                        name_count_in = name_count_ff + PW'(1);
                     end else if (kvlp_pkg::is_blank(ch)) begin
                        phase_in = kvlp_pkg::PH_PRE_EQ;
                     end else if (ch == kvlp_pkg::CH_EQ) begin
                        phase_in = kvlp_pkg::PH_POST_EQ;
                     end else begin
                        err_in = 1'b1;
                     end
                  end
                  kvlp_pkg::PH_PRE_EQ: begin
                     if (ch == kvlp_pkg::CH_EQ) begin
                        phase_in = kvlp_pkg::PH_POST_EQ;
                     end else if (!kvlp_pkg::is_blank(ch)) begin
                        err_in = 1'b1;
                     end
                  end
                  kvlp_pkg::PH_POST_EQ: begin
                     if (ch == kvlp_pkg::CH_QUOTE) begin
                        phase_in     = kvlp_pkg::PH_QVALUE;
                        quoted_in    = 1'b1;
                        val_start_in = pos1;
                     end else if (!kvlp_pkg::is_blank(ch)) begin
                        phase_in     = kvlp_pkg::PH_VALUE;
                        val_start_in = pos_ff;
                     end
                  end
                  kvlp_pkg::PH_QVALUE: begin
                     if (ch == kvlp_pkg::CH_QUOTE) begin
                        lq_in      = pos_ff;
                        lq_seen_in = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
      end

      if (last) begin
         if (err_in) begin
            res.status = kvlp_pkg::ST_ERROR;
         end else begin
            case (phase_in)
               kvlp_pkg::PH_LEAD: begin
                  res.status = kvlp_pkg::ST_BLANK;
               end
               kvlp_pkg::PH_POST_EQ: begin
                  res.status = kvlp_pkg::ST_PARSED;
                  wide       = WIDE'(lnb_in);
                  res.value_pos = wide[kvlp_pkg::SPAN_W-1:0];
               end
               kvlp_pkg::PH_VALUE: begin
                  res.status = kvlp_pkg::ST_PARSED;
                  vlen       = lnb_in - val_start_in;
               end
               kvlp_pkg::PH_QVALUE: begin
                  if (lq_seen_in) begin
                     res.status = kvlp_pkg::ST_PARSED;
                     vlen       = lq_in - val_start_in;
                  end else begin
                     res.status = kvlp_pkg::ST_ERROR;
                  end
               end
               default: begin
                  res.status = kvlp_pkg::ST_ERROR;
               end
            endcase
            if (res.status == kvlp_pkg::ST_PARSED) begin
               if (phase_in != kvlp_pkg::PH_POST_EQ) begin
                  wide = WIDE'(val_start_in);
                  res.value_pos = wide[kvlp_pkg::SPAN_W-1:0];
                  wide = WIDE'(vlen);
                  res.value_length = wide[kvlp_pkg::SPAN_W-1:0];
               end
               wide = WIDE'(name_start_in);
               res.option_pos = wide[kvlp_pkg::SPAN_W-1:0];
               wide = WIDE'(name_count_in);
               res.option_length = wide[kvlp_pkg::SPAN_W-1:0];
            end
         end
         phase_in      = kvlp_pkg::PH_LEAD;
         pos_in        = '0;
         inq_in        = 1'b0;
         cut_in        = 1'b0;
         name_start_in = '0;
         name_count_in = '0;
         val_start_in  = '0;
         quoted_in     = 1'b0;
         lnb_in        = '0;
         lq_in         = '0;
         lq_seen_in    = 1'b0;
         err_in        = 1'b0;
      end
   end

   assign res_valid = go && last;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= kvlp_pkg::PH_LEAD;
         pos_ff        <= '0;
         inq_ff        <= 1'b0;
         cut_ff        <= 1'b0;
         name_start_ff <= '0;
         name_count_ff <= '0;
         val_start_ff  <= '0;
         quoted_ff     <= 1'b0;
         lnb_ff        <= '0;
         lq_ff         <= '0;
         lq_seen_ff    <= 1'b0;
         err_ff        <= 1'b0;
      end else if (go) begin
         phase_ff      <= phase_in;
         pos_ff        <= pos_in;
         inq_ff        <= inq_in;
         cut_ff        <= cut_in;
         name_start_ff <= name_start_in;
         name_count_ff <= name_count_in;
         val_start_ff  <= val_start_in;
         quoted_ff     <= quoted_in;
         lnb_ff        <= lnb_in;
         lq_ff         <= lq_in;
         lq_seen_ff    <= lq_seen_in;
         err_ff        <= err_in;
      end
   end

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= PW'(MAX_LINE))
      else $error("line position ran past the maximum line length");

   a_line_restart: assert property (@(posedge clock) disable iff (reset)
      go && last |=> pos_ff == '0 && phase_ff == kvlp_pkg::PH_LEAD && !err_ff)
      else $error("state not cleared after the end of a line");

   a_name_nonempty: assert property (@(posedge clock) disable iff (reset)
      phase_ff != kvlp_pkg::PH_LEAD |-> name_count_ff != '0)
      else $error("option name phase left with an empty name");

   a_spans_zero: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.status != kvlp_pkg::ST_PARSED |->
         res.option_pos == '0 && res.option_length == '0 &&
         res.value_pos == '0 && res.value_length == '0)
      else $error("spans reported on a line that did not parse");

   a_quoted_phase: assert property (@(posedge clock) disable iff (reset)
      phase_ff == kvlp_pkg::PH_QVALUE |-> quoted_ff)
      else $error("quoted value phase without the quoted flag");

endmodule

FILE: design/kvlp_out_stage.sv
// ----------------------------------------------------------------------------
// Key/value line parser output stage
// Result register of the line parser, held while the receiver stalls.
// ----------------------------------------------------------------------------
module kvlp_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 res_valid,
   input  kvlp_pkg::result_type res,
   output logic                 out_free,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output kvlp_pkg::result_type rsp_res
);

   logic                 valid_ff;
   kvlp_pkg::result_type res_ff;

   assign out_free = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (res_valid) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         res_ff <= res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_res   = res_ff;

endmodule

FILE: design/key_value_line_parser_unit.sv
// ----------------------------------------------------------------------------
// Key/value line parser unit
// Parses "name = value" configuration lines one character per transaction.
// ----------------------------------------------------------------------------
// The block takes one character per clock cycle while req_stall is low
// and returns one result per line: the character flagged as last passes
// from the input register through the phase machine into the result
// register. Characters keep flowing while a result waits; the input side
// stalls only when a line's last character reaches the phase machine while
// the previous result is still held by a stalled receiver. Lines longer
// than MAX_LINE characters report a parse error.
module key_value_line_parser_unit #(
   parameter int MAX_LINE = kvlp_pkg::MAX_LINE_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_ch,
   input  logic       req_last_char,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_status,
   output logic [kvlp_pkg::SPAN_W-1:0] rsp_option_pos,
   output logic [kvlp_pkg::SPAN_W-1:0] rsp_option_length,
   output logic [kvlp_pkg::SPAN_W-1:0] rsp_value_pos,
   output logic [kvlp_pkg::SPAN_W-1:0] rsp_value_length
);

   logic                 in_valid;
   logic [7:0]           in_ch;
   logic                 in_last;
   logic                 go;
   logic                 out_free;
   logic                 res_valid;
   kvlp_pkg::result_type res;
   kvlp_pkg::result_type rsp_res;

   assign go = in_valid && (!in_last || out_free);

   kvlp_in_stage u_in (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_ch        (req_ch),
      .req_last_char (req_last_char),
      .go            (go),
      .in_valid      (in_valid),
      .in_ch         (in_ch),
      .in_last       (in_last)
   );

   kvlp_parse #(
      .MAX_LINE (MAX_LINE)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .go        (go),
      .ch        (in_ch),
      .last      (in_last),
      .res_valid (res_valid),
      .res       (res)
   );

   kvlp_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_res   (rsp_res)
   );

   assign rsp_status        = rsp_res.status;
   assign rsp_option_pos    = rsp_res.option_pos;
   assign rsp_option_length = rsp_res.option_length;
   assign rsp_value_pos     = rsp_res.value_pos;
   assign rsp_value_length  = rsp_res.value_length;

endmodule
